@@ src/fsp_pkg.sv @@
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants for the format specifier parser: character
// codes, the parse phase encoding and the layout of one parsed specifier.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned NUM_W   = 31;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned DIGIT_W = 4;

  // Largest value either decimal number may reach.
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
  // Accumulator value above which one more digit always overflows.
  localparam logic [NUM_W-1:0] ACC_LIMIT = NUM_W'(NUM_MAX / 10);
  // Largest digit that may still be appended to ACC_LIMIT.
  localparam logic [DIGIT_W-1:0] ACC_LAST_DIGIT = DIGIT_W'(NUM_MAX % 10);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Sign mode codes.
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_SPACE = 2'd1;
  localparam logic [1:0] SIGN_PLUS  = 2'd2;

  // Character codes.
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

  // Parse phase.
  typedef enum logic [2:0] {
    PH_FLAGS = 3'b001,
    PH_WIDTH = 3'b010,
    PH_PREC  = 3'b100
  } phase_t;

  // One parsed conversion specifier.
  typedef struct packed {
    logic [CNT_W-1:0] consumed;
    logic [CH_W-1:0]  conversion;
    logic             prec_given;
    logic [NUM_W-1:0] prec_value;
    logic [NUM_W-1:0] field_width;
    logic             zero_pad;
    logic             alternate;
    logic [1:0]       sign_mode;
    logic             left_adjust;
  } spec_t;

  localparam int unsigned SPEC_W = $bits(spec_t);
  localparam int unsigned TDATA_W = ((SPEC_W + 7) / 8) * 8;

endpackage

@@ src/fsp_acc.sv @@
// ----------------------------------------------------------------------------
// fsp_acc
// Saturating decimal accumulate: acc * 10 + digit, clamped at NUM_MAX.
// ----------------------------------------------------------------------------
module fsp_acc (
  input  logic [fsp_pkg::NUM_W-1:0]   acc,
  input  logic [fsp_pkg::DIGIT_W-1:0] digit,
  output logic [fsp_pkg::NUM_W-1:0]   sum
);
  import fsp_pkg::*;

  logic [NUM_W+2:0] times10;
  logic             ovf;

  // Shift-and-add multiply by ten.
  assign times10 = {acc, 3'b000} + {2'b00, acc, 1'b0};

  assign ovf = (acc > ACC_LIMIT) || ((acc == ACC_LIMIT) && (digit > ACC_LAST_DIGIT));

  assign sum = ovf ? NUM_MAX
                   : times10[NUM_W-1:0] + {{(NUM_W-DIGIT_W){1'b0}}, digit};

endmodule

@@ src/fsp_parse.sv @@
// ----------------------------------------------------------------------------
// fsp_parse
// Parse state registers and the per-character update. When step is high the
// character is consumed; emit tells whether it closed a specifier.
// ----------------------------------------------------------------------------
module fsp_parse (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [fsp_pkg::CH_W-1:0] ch,
  output logic                     emit,
  output fsp_pkg::spec_t           result
);
  import fsp_pkg::*;

  phase_t           phase, phase_next;
  logic             minus_seen, minus_seen_next;
  logic [1:0]       sign_held, sign_held_next;
  logic             hash_seen, hash_seen_next;
  logic             zero_seen, zero_seen_next;
  logic [NUM_W-1:0] width_acc, width_acc_next;
  logic [NUM_W-1:0] prec_acc, prec_acc_next;
  logic             dot_seen, dot_seen_next;
  logic [CNT_W-1:0] char_count, char_count_next;

  logic [CNT_W-1:0]   cnt_inc;
  logic               is_digit;
  logic [DIGIT_W-1:0] digit;
  logic [NUM_W-1:0]   acc_in;
  logic [NUM_W-1:0]   acc_out;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  // '0'..'9' are 0x30..0x39, so the low nibble is the digit value.
  assign digit    = ch[DIGIT_W-1:0];
  assign cnt_inc  = (char_count != CNT_MAX) ? char_count + 1'b1 : char_count;
  assign acc_in   = (phase == PH_PREC) ? prec_acc : width_acc;

  fsp_acc u_acc (
    .acc   (acc_in),
    .digit (digit),
    .sum   (acc_out)
  );

  always_comb begin
    phase_next      = phase;
    minus_seen_next = minus_seen;
    sign_held_next  = sign_held;
    hash_seen_next  = hash_seen;
    zero_seen_next  = zero_seen;
    width_acc_next  = width_acc;
    prec_acc_next   = prec_acc;
    dot_seen_next   = dot_seen;
    char_count_next = cnt_inc;
    emit            = 1'b0;

    unique case (phase)
      PH_WIDTH: begin
        if (is_digit) begin
          width_acc_next = acc_out;
        end else if (ch == CH_DOT) begin
          dot_seen_next = 1'b1;
          phase_next    = PH_PREC;
        end else begin
          emit = 1'b1;
        end
      end
      PH_PREC: begin
        if (is_digit) begin
          prec_acc_next = acc_out;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        if (ch == CH_MINUS) begin
          minus_seen_next = 1'b1;
        end else if (ch == CH_SPACE) begin
          if (sign_held != SIGN_PLUS) begin
            sign_held_next = SIGN_SPACE;
          end
        end else if (ch == CH_PLUS) begin
          sign_held_next = SIGN_PLUS;
        end else if (ch == CH_HASH) begin
          hash_seen_next = 1'b1;
        end else if (ch == CH_ZERO) begin
          zero_seen_next = 1'b1;
        end else if (is_digit) begin
          width_acc_next = {{(NUM_W-DIGIT_W){1'b0}}, digit};
          phase_next     = PH_WIDTH;
        end else if (ch == CH_DOT) begin
          dot_seen_next = 1'b1;
          phase_next    = PH_PREC;
        end else begin
          emit = 1'b1;
        end
      end
    endcase

    // A conversion character closes the specifier and clears everything.
    if (emit) begin
      phase_next      = PH_FLAGS;
      minus_seen_next = 1'b0;
      sign_held_next  = SIGN_NONE;
      hash_seen_next  = 1'b0;
      zero_seen_next  = 1'b0;
      width_acc_next  = '0;
      prec_acc_next   = '0;
      dot_seen_next   = 1'b0;
      char_count_next = '0;
    end
  end

  always_comb begin
    result.left_adjust = minus_seen;
    result.sign_mode   = sign_held;
    result.alternate   = hash_seen;
    result.zero_pad    = zero_seen & ~minus_seen;
    result.field_width = width_acc;
    result.prec_value  = prec_acc;
    result.prec_given  = dot_seen;
    result.conversion  = ch;
    result.consumed    = cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAGS;
      minus_seen <= 1'b0;
      sign_held  <= SIGN_NONE;
      hash_seen  <= 1'b0;
      zero_seen  <= 1'b0;
      width_acc  <= '0;
      prec_acc   <= '0;
      dot_seen   <= 1'b0;
      char_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      minus_seen <= minus_seen_next;
      sign_held  <= sign_held_next;
      hash_seen  <= hash_seen_next;
      zero_seen  <= zero_seen_next;
      width_acc  <= width_acc_next;
      prec_acc   <= prec_acc_next;
      dot_seen   <= dot_seen_next;
      char_count <= char_count_next;
    end
  end

endmodule

@@ src/format_spec_parser_core.sv @@
// A conversion character is captured in the input register; the parser then
// steps on it from there and loads the result register, which drives the
// master side. Throughput: one character per cycle, except while a closing
// character waits for an occupied result register to be taken. Reset (rst,
// synchronous, active high) empties both registers and returns the parser to
// the flag phase with all fields cleared.
// ----------------------------------------------------------------------------
// format_spec_parser_core
// Streaming parser for printf-style conversion specifiers. Takes one format
// character per transaction and emits one parsed specifier per conversion.
// ----------------------------------------------------------------------------
module format_spec_parser_core (
  input  logic                        clk,
  input  logic                        rst,
  // Slave side: tdata[7:0] = ch.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fsp_pkg::CH_W-1:0]    s_tdata,
  // Master side, from bit 0 up: left_adjust[0], sign_mode[2:1], alternate[3],
  // zero_pad[4], field_width[35:5], prec_value[66:36], prec_given[67],
  // conversion[75:68], consumed[91:76], zero fill[95:92].
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fsp_pkg::TDATA_W-1:0] m_tdata
);
  import fsp_pkg::*;

  // Input register: holds one character until the parser consumes it.
  logic            in_valid;
  logic [CH_W-1:0] in_ch;

  // Result register: holds one finished specifier until it is taken.
  logic  out_valid;
  spec_t out_spec;

  logic  emit;
  spec_t spec;
  logic  advance;

  // The parser steps on the held character every cycle, unless that
  // character closes a specifier and the result register is still occupied
  // by one the downstream side has not taken. Characters that produce no
  // result never wait on the master side.
  assign advance  = in_valid && (!emit || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  fsp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .ch     (in_ch),
    .emit   (emit),
    .result (spec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ch <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_spec <= spec;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TDATA_W-SPEC_W){1'b0}}, out_spec};

endmodule
